// File: design/dark_span_observation_extractor_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dark span observation extractor
// Concurrent checks compile in simulation and drop out for synthesis.
// ---------------------------------------------------------------------------
`ifndef DARK_SPAN_OBSERVATION_EXTRACTOR_TOP_DEFINES_SVH
`define DARK_SPAN_OBSERVATION_EXTRACTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dse: same-cycle check failed");
// next-cycle implication
`define DSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dse: next-cycle check failed");
`else
`define DSE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DSE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/dse_pkg.sv
// ---------------------------------------------------------------------------
// Dark span extractor package
// Widths, register indexes, payload types and controller interface types.
// ---------------------------------------------------------------------------
package dse_pkg;

   localparam int LINE_WIDTH = 4096;
   localparam int IDX_W      = $clog2(LINE_WIDTH);
   localparam int LEN_W      = IDX_W + 1;
   localparam int PIX_W      = 8;
   localparam int RATIO_W    = 9;
   localparam int PROD_W     = PIX_W + RATIO_W;
   localparam int LEVEL_W    = PIX_W + 2;
   localparam int SUM_W      = PIX_W + IDX_W;
   localparam int DIVD_W     = SUM_W + 8;
   localparam int DCNT_W     = $clog2(DIVD_W);
   localparam int CENTER_W   = 12;
   localparam int THICK_W    = 13;
   localparam int MEAN_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RATIO_W;

   localparam logic [PIX_W-1:0]   DARK_LIMIT_RST  = 8'd128;
   localparam logic [RATIO_W-1:0] ACCEPT_RATIO_RST = 9'd128;
   localparam logic [PIX_W-1:0]   DARKEST_RST     = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DARK_LIMIT   = 1'b0,
      CSR_ACCEPT_RATIO = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             line_end;
   } req_payload_type;

   typedef struct packed {
      logic [CENTER_W-1:0] span_center;
      logic [THICK_W-1:0]  span_thickness;
      logic [MEAN_W-1:0]   span_mean_q8;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEVEL,
      S_FRONT_RD,
      S_FRONT_CK,
      S_BACK_RD,
      S_BACK_CK,
      S_SUM,
      S_SUM_LAST,
      S_DIV_INIT,
      S_DIV,
      S_OUT
   } dse_state_type;

   typedef struct packed {
      logic accept;
      logic calc_level;
      logic rd_first;
      logic inc_first;
      logic rd_last;
      logic dec_last;
      logic sum_init;
      logic rd_sum;
      logic div_init;
      logic div_step;
      logic out_load;
   } dse_cmd_type;

   typedef struct packed {
      logic close_now;
      logic front_more;
      logic back_more;
      logic rd_above;
      logic sum_at_last;
      logic div_last;
      logic rsp_free;
   } dse_status_type;

endpackage

// File: design/dse_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/dse_ctrl.sv
// ---------------------------------------------------------------------------
// Dark span extractor controller
// Sequences pixel intake, level setup, trimming, summing, division and output.
// ---------------------------------------------------------------------------
module dse_ctrl
   import dse_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  dse_status_type status,
   output dse_cmd_type    cmd
);

   dse_state_type state_ff;
   dse_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.close_now) begin
                  state_in = S_LEVEL;
               end
            end
         end
         S_LEVEL: begin
            cmd.calc_level = 1'b1;
            state_in       = S_FRONT_RD;
         end
         S_FRONT_RD: begin
            if (status.front_more) begin
               cmd.rd_first = 1'b1;
               state_in     = S_FRONT_CK;
            end else begin
               state_in = S_BACK_RD;
            end
         end
         S_FRONT_CK: begin
            if (status.rd_above) begin
               cmd.inc_first = 1'b1;
               state_in      = S_FRONT_RD;
            end else begin
               state_in = S_BACK_RD;
            end
         end
         S_BACK_RD: begin
            if (status.back_more) begin
               cmd.rd_last = 1'b1;
               state_in    = S_BACK_CK;
            end else begin
               cmd.sum_init = 1'b1;
               state_in     = S_SUM;
            end
         end
         S_BACK_CK: begin
            if (status.rd_above) begin
               cmd.dec_last = 1'b1;
               state_in     = S_BACK_RD;
            end else begin
               cmd.sum_init = 1'b1;
               state_in     = S_SUM;
            end
         end
         S_SUM: begin
            cmd.rd_sum = 1'b1;
            if (status.sum_at_last) begin
               state_in = S_SUM_LAST;
            end
         end
         S_SUM_LAST: begin
            // last read word lands in the accumulator this cycle
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: design/dse_datapath.sv
// ---------------------------------------------------------------------------
// Dark span extractor datapath
// Span tracking, span buffer, trim pointers, accumulator, divider, output.
// ---------------------------------------------------------------------------
module dse_datapath
   import dse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  dse_cmd_type           cmd,
   output dse_status_type        status
);

   // configuration
   logic [PIX_W-1:0]   limit_ff, limit_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;

   // open span tracking
   logic [IDX_W-1:0] index_ff, index_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [PIX_W-1:0] darkest_ff, darkest_in;
   logic             in_span_ff, in_span_in;

   // span being closed
   logic [IDX_W-1:0]   cls_start_ff, cls_start_in;
   logic [PIX_W-1:0]   cls_dark_ff, cls_dark_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [IDX_W-1:0]   first_ff, first_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic [IDX_W-1:0]   sidx_ff, sidx_in;
   logic               spend_ff, spend_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [LEN_W-1:0]   thick_ff, thick_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [DIVD_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic             dark;
   logic [LEN_W-1:0] len_base;
   logic [LEN_W-1:0] len_new;
   logic [PIX_W-1:0] dk_base;
   logic [PIX_W-1:0] dk_new;
   logic             wr_en;
   logic [PIX_W-1:0] gap;
   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0] rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic [LEN_W:0]   partial;
   logic             ge;
   logic [LEN_W-1:0] thick_cur;

   dse_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_WIDTH)
   ) u_span_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_base[IDX_W-1:0]),
      .wr_data (req_payload.pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      dark     = (req_payload.pixel < limit_ff);
      len_base = in_span_ff ? len_ff : '0;
      dk_base  = in_span_ff ? darkest_ff : DARKEST_RST;
      wr_en    = cmd.accept && dark && (len_base < LEN_W'(LINE_WIDTH));
      len_new  = len_base;
      dk_new   = dk_base;
      if (dark && (len_base < LEN_W'(LINE_WIDTH))) begin
         len_new = len_base + LEN_W'(1);
         if (req_payload.pixel < dk_base) begin
            dk_new = req_payload.pixel;
         end
      end

      gap  = (limit_ff > cls_dark_ff) ? (limit_ff - cls_dark_ff) : '0;
      prod = PROD_W'(gap) * PROD_W'(ratio_ff);

      if (cmd.rd_first) begin
         rd_addr = first_ff;
      end else if (cmd.rd_last) begin
         rd_addr = last_ff;
      end else begin
         rd_addr = sidx_ff;
      end

      thick_cur = LEN_W'(last_ff) - LEN_W'(first_ff) + LEN_W'(1);
      partial   = {rem_ff, quo_ff[DIVD_W-1]};
      ge        = (partial >= {1'b0, thick_ff});
   end

   always_comb begin
      status.close_now   = (dark && req_payload.line_end) || (!dark && in_span_ff);
      status.front_more  = (first_ff < last_ff);
      status.back_more   = (last_ff > first_ff);
      status.rd_above    = ({2'b00, rd_data} > level_ff);
      status.sum_at_last = (sidx_ff == last_ff);
      status.div_last    = (dcnt_ff == '0);
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      limit_in     = limit_ff;
      ratio_in     = ratio_ff;
      index_in     = index_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      darkest_in   = darkest_ff;
      in_span_in   = in_span_ff;
      cls_start_in = cls_start_ff;
      cls_dark_in  = cls_dark_ff;
      level_in     = level_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      sidx_in      = sidx_ff;
      spend_in     = cmd.rd_sum;
      sum_in       = sum_ff;
      thick_in     = thick_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DARK_LIMIT:   limit_in = csr_data[PIX_W-1:0];
            CSR_ACCEPT_RATIO: ratio_in = csr_data;
         endcase
      end

      if (cmd.accept) begin
         // snapshot the closing span before the tracking state is cleared
         cls_start_in = (dark && !in_span_ff) ? index_ff : start_ff;
         cls_dark_in  = dark ? dk_new : darkest_ff;
         last_in      = dark ? IDX_W'(len_new - LEN_W'(1)) : IDX_W'(len_ff - LEN_W'(1));
         if (status.close_now || req_payload.line_end) begin
            in_span_in = 1'b0;
            len_in     = '0;
            darkest_in = DARKEST_RST;
         end else if (dark) begin
            in_span_in = 1'b1;
            len_in     = len_new;
            darkest_in = dk_new;
            if (!in_span_ff) begin
               start_in = index_ff;
            end
         end
         if (req_payload.line_end || (index_ff == IDX_W'(LINE_WIDTH - 1))) begin
            index_in = '0;
         end else begin
            index_in = index_ff + IDX_W'(1);
         end
      end

      if (cmd.calc_level) begin
         level_in = LEVEL_W'(cls_dark_ff) + LEVEL_W'(prod[PROD_W-1:8]);
         first_in = '0;
      end
      if (cmd.inc_first) begin
         first_in = first_ff + IDX_W'(1);
      end
      if (cmd.dec_last) begin
         last_in = last_ff - IDX_W'(1);
      end

      if (cmd.sum_init) begin
         sidx_in = first_ff;
         sum_in  = '0;
      end
      if (cmd.rd_sum) begin
         sidx_in = sidx_ff + IDX_W'(1);
      end
      // read data arrives in the cycle after the address
      if (spend_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data);
      end

      if (cmd.div_init) begin
         thick_in = thick_cur;
         rem_in   = '0;
         quo_in   = {sum_ff, 8'h00};
         dcnt_in  = DCNT_W'(DIVD_W - 1);
      end
      if (cmd.div_step) begin
         rem_in  = ge ? LEN_W'(partial - {1'b0, thick_ff}) : partial[LEN_W-1:0];
         quo_in  = {quo_ff[DIVD_W-2:0], ge};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_in.span_center    = CENTER_W'(cls_start_ff) + CENTER_W'(first_ff)
                                 + CENTER_W'(thick_ff[LEN_W-1:1]);
         rsp_in.span_thickness = THICK_W'(thick_ff);
         rsp_in.span_mean_q8   = quo_ff[MEAN_W-1:0];
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= DARK_LIMIT_RST;
         ratio_ff     <= ACCEPT_RATIO_RST;
         index_ff     <= '0;
         start_ff     <= '0;
         len_ff       <= '0;
         darkest_ff   <= DARKEST_RST;
         in_span_ff   <= 1'b0;
         spend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         ratio_ff     <= ratio_in;
         index_ff     <= index_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
         darkest_ff   <= darkest_in;
         in_span_ff   <= in_span_in;
         spend_ff     <= spend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cls_start_ff <= cls_start_in;
      cls_dark_ff  <= cls_dark_in;
      level_ff     <= level_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      sidx_ff      <= sidx_in;
      sum_ff       <= sum_in;
      thick_ff     <= thick_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/dark_span_observation_extractor_top.sv
// ---------------------------------------------------------------------------
// Dark span observation extractor
// Finds dark pixel spans along a line, trims them against a relative level
// and reports center, thickness and Q8 mean of each trimmed span.
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_stall   pixel, line_end
//  rsp      rsp_valid/rsp_stall   span_center, span_thickness, span_mean_q8
//  csr      csr_valid/csr_ready   csr_index, csr_data
//
// A pixel that does not close a span is taken without a stall. After a
// closing pixel req_stall stays high while the level is set, the span is
// trimmed (a read and a check per step), summed, divided in 28 steps and
// the result loaded. A waiting result only blocks the next close.
// Reset is synchronous; the span buffer needs no clearing.
// ---------------------------------------------------------------------------
`include "dark_span_observation_extractor_top_defines.svh"

module dark_span_observation_extractor_top
   import dse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dse_cmd_type    cmd;
   dse_status_type status;

   assign csr_ready = 1'b1;

   dse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dse_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

   // one buffer read source per cycle
   `DSE_ASSERT_IMP(a_rd_onehot, clock, reset, 1'b1, ($onehot0({cmd.rd_first, cmd.rd_last, cmd.rd_sum})))
   // a new result never overwrites one still waiting
   `DSE_ASSERT_IMP(a_out_free, clock, reset, cmd.out_load, (!rsp_valid || !rsp_stall))
   // no transaction is taken while a span is being processed
   `DSE_ASSERT_IMP(a_accept_idle, clock, reset, cmd.accept, (!cmd.rd_sum && !cmd.div_step && !cmd.calc_level))
   // a loaded result shows up on the output next cycle
   `DSE_ASSERT_NXT(a_out_valid, clock, reset, cmd.out_load, rsp_valid)

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Dark span observation extractor testbench
// Drives pixel lines with random idle and stall and predicts each trimmed
// span result in the bench except for typed rows. A short stimulus table
// comes first, then random lines under a sweep of limit and ratio settings.
// ---------------------------------------------------------------------------
module tb_top;
   import dse_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned SWEEP_ITEMS = 130;
   localparam int NUM_ROWS = 23;
   localparam int NUM_SWEEP = 11;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             line_end;
      logic             typed;
      rsp_payload_type  want;
   } stim_row_type;

   localparam rsp_payload_type NO_SPAN = '0;

   // rows with typed set carry a hand-computed result for the span they close
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{8'd0,   1'b0, 1'b0, NO_SPAN},
      '{8'd255, 1'b0, 1'b1, {12'd0, 13'd1, 16'd0}},
      '{8'd127, 1'b0, 1'b0, NO_SPAN},
      '{8'd128, 1'b0, 1'b1, {12'd2, 13'd1, 16'd32512}},
      '{8'd255, 1'b1, 1'b0, NO_SPAN},
      '{8'd0,   1'b1, 1'b1, {12'd0, 13'd1, 16'd0}},
      '{8'd100, 1'b0, 1'b0, NO_SPAN},
      '{8'd10,  1'b0, 1'b0, NO_SPAN},
      '{8'd20,  1'b0, 1'b0, NO_SPAN},
      '{8'd120, 1'b0, 1'b0, NO_SPAN},
      '{8'd200, 1'b0, 1'b0, NO_SPAN},
      '{8'd50,  1'b0, 1'b0, NO_SPAN},
      '{8'd60,  1'b1, 1'b0, NO_SPAN},
      '{8'd90,  1'b0, 1'b0, NO_SPAN},
      '{8'd200, 1'b1, 1'b0, NO_SPAN},
      '{8'd255, 1'b0, 1'b0, NO_SPAN},
      '{8'd5,   1'b0, 1'b0, NO_SPAN},
      '{8'd127, 1'b0, 1'b0, NO_SPAN},
      '{8'd5,   1'b0, 1'b0, NO_SPAN},
      '{8'd255, 1'b0, 1'b0, NO_SPAN},
      '{8'd127, 1'b0, 1'b0, NO_SPAN},
      '{8'd127, 1'b0, 1'b0, NO_SPAN},
      '{8'd127, 1'b1, 1'b0, NO_SPAN}
   };

   localparam logic [PIX_W-1:0] LIMIT_SWEEP [NUM_SWEEP] = '{
      8'd128, 8'd255, 8'd255, 8'd0, 8'd1, 8'd1, 8'd255, 8'd200, 8'd64, 8'd100, 8'd255
   };
   localparam logic [RATIO_W-1:0] RATIO_SWEEP [NUM_SWEEP] = '{
      9'd128, 9'd256, 9'd511, 9'd0, 9'd0, 9'd511, 9'd0, 9'd300, 9'd256, 9'd1, 9'd128
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // span predictor state
   logic [PIX_W-1:0]   span_buf [LINE_WIDTH];
   logic [IDX_W-1:0]   col_idx = '0;
   logic [IDX_W-1:0]   open_start = '0;
   logic [LEN_W-1:0]   open_len = '0;
   logic [PIX_W-1:0]   open_min = DARKEST_RST;
   bit                 span_open = 1'b0;
   logic [PIX_W-1:0]   cfg_limit = DARK_LIMIT_RST;
   logic [RATIO_W-1:0] cfg_ratio = ACCEPT_RATIO_RST;

   rsp_payload_type expected_spans [$];
   bit              drv_typed = 1'b0;
   rsp_payload_type drv_want = '0;
   bit              drv_calm = 1'b0;
   bit              rsp_calm = 1'b0;
   int unsigned     drv_count = 0;
   int unsigned     rsp_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     err_count = 0;

   dark_span_observation_extractor_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic note_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      err_count++;
   endtask

   task automatic queue_span(input rsp_payload_type span);
      expected_spans.insert(expected_spans.size(), span);
   endtask

   function automatic int unsigned pick_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // trim the open span against its accept level and describe what is left
   function automatic rsp_payload_type trimmed_span();
      int unsigned gap, level, trim_lo, trim_hi, thick, total, i;
      rsp_payload_type r;
      gap = (cfg_limit > open_min) ? cfg_limit - open_min : 0;
      level = open_min + ((gap * cfg_ratio) >> 8);
      trim_lo = 0;
      trim_hi = 32'(open_len) - 1;
      while (trim_lo < trim_hi && span_buf[IDX_W'(trim_lo)] > level)
         trim_lo++;
      while (trim_hi > trim_lo && span_buf[IDX_W'(trim_hi)] > level)
         trim_hi--;
      thick = trim_hi - trim_lo + 1;
      total = 0;
      for (i = trim_lo; i <= trim_hi; i++)
         total += span_buf[IDX_W'(i)];
      r.span_center = CENTER_W'(open_start + trim_lo + thick / 2);
      r.span_thickness = THICK_W'(thick);
      r.span_mean_q8 = MEAN_W'((longint'(total) * 256) / thick);
      span_open = 1'b0;
      open_len = '0;
      open_min = DARKEST_RST;
      return r;
   endfunction

   function automatic void advance_span_model(input req_payload_type item,
                                              output bit emits,
                                              output rsp_payload_type res);
      emits = 1'b0;
      res = '0;
      if (item.pixel < cfg_limit) begin
         if (!span_open) begin
            span_open = 1'b1;
            open_start = col_idx;
            open_len = '0;
            open_min = DARKEST_RST;
         end
         // span buffer saturates; extra dark pixels are dropped
         if (open_len < LINE_WIDTH) begin
            span_buf[open_len[IDX_W-1:0]] = item.pixel;
            open_len++;
            if (item.pixel < open_min)
               open_min = item.pixel;
         end
         if (item.line_end) begin
            res = trimmed_span();
            emits = 1'b1;
         end
      end else if (span_open) begin
         res = trimmed_span();
         emits = 1'b1;
      end
      if (item.line_end) begin
         col_idx = '0;
         span_open = 1'b0;
         open_len = '0;
         open_min = DARKEST_RST;
      end else begin
         col_idx = col_idx + 1'b1;
      end
   endfunction

   function automatic logic [PIX_W-1:0] dark_level(input bit valley, input bit at_rim);
      if (!valley)
         return PIX_W'($urandom_range(0, cfg_limit - 1));
      if (at_rim)
         return PIX_W'($urandom_range(cfg_limit - 1 - (cfg_limit - 1) / 4, cfg_limit - 1));
      return PIX_W'($urandom_range(0, (cfg_limit - 1) / 2));
   endfunction

   always @(posedge clock) begin : monitor
      bit              emits;
      rsp_payload_type res;
      rsp_payload_type want;
      if (!reset) begin
         cycle_count++;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_DARK_LIMIT:   cfg_limit = csr_data[PIX_W-1:0];
               CSR_ACCEPT_RATIO: cfg_ratio = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_span_model(req_payload, emits, res);
            if (drv_typed)
               queue_span(drv_want);
            else if (emits)
               queue_span(res);
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               note_mismatch($sformatf("unexpected span: center %0d thickness %0d mean %0d",
                  rsp_payload.span_center, rsp_payload.span_thickness,
                  rsp_payload.span_mean_q8));
            end else begin
               want = expected_spans.pop_front();
               if (rsp_payload.span_center !== want.span_center)
                  note_mismatch($sformatf("span_center %0d, expected %0d",
                     rsp_payload.span_center, want.span_center));
               if (rsp_payload.span_thickness !== want.span_thickness)
                  note_mismatch($sformatf("span_thickness %0d, expected %0d",
                     rsp_payload.span_thickness, want.span_thickness));
               if (rsp_payload.span_mean_q8 !== want.span_mean_q8)
                  note_mismatch($sformatf("span_mean_q8 %0d, expected %0d",
                     rsp_payload.span_mean_q8, want.span_mean_q8));
            end
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            note_mismatch("timeout waiting for the extractor");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // result side: hold rsp_stall for a random gap from pick_gap before each transaction
   initial begin : span_sink
      int unsigned n;
      rsp_stall = 1'b0;
      forever begin
         n = pick_gap(rsp_calm);
         if (n != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         rsp_count++;
         if (rsp_count % 40 == 0)
            rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_pixel(input req_payload_type item, input bit typed,
                             input rsp_payload_type want);
      int unsigned gap;
      gap = pick_gap(drv_calm);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      drv_typed <= typed;
      drv_want <= want;
      do @(posedge clock); while (req_stall !== 1'b0);
      drv_count++;
      if (drv_count % 40 == 0)
         drv_calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers change only once every span result is back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_spans.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_levels(input logic [PIX_W-1:0] limit, input logic [RATIO_W-1:0] ratio);
      wait_idle();
      // bit 8 is ignored for the limit register
      write_reg(CSR_DARK_LIMIT, {1'($urandom_range(0, 1)), limit});
      write_reg(CSR_ACCEPT_RATIO, ratio);
   endtask

   // random lines: mostly alternating bright and dark runs, some noise lines
   task automatic run_lines(input int unsigned quota);
      int unsigned     sent, left, run, k, rim;
      bit              dark, noise, valley, stop;
      req_payload_type item;
      sent = 0;
      while (sent < quota) begin
         left = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 40);
         noise = ($urandom_range(0, 4) == 0);
         dark = 1'($urandom_range(0, 1));
         stop = 1'b0;
         while (!stop) begin
            run = $urandom_range(1, 12);
            if (run > left)
               run = left;
            valley = 1'($urandom_range(0, 1));
            rim = $urandom_range(1, 2);
            for (k = 0; k < run && !stop; k++) begin
               if (noise)
                  item.pixel = PIX_W'($urandom_range(0, 255));
               else if (dark && cfg_limit != 0)
                  item.pixel = dark_level(valley, k < rim || k + rim >= run);
               else
                  item.pixel = PIX_W'($urandom_range(cfg_limit, 255));
               left--;
               item.line_end = (left == 0) || (noise && $urandom_range(0, 15) == 0);
               stop = item.line_end;
               send_pixel(item, 1'b0, NO_SPAN);
               sent++;
            end
            dark = !dark;
         end
      end
   endtask

   initial begin : stimulus
      req_payload_type item;
      int              i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         item.pixel = DIRECTED_ROWS[i].pixel;
         item.line_end = DIRECTED_ROWS[i].line_end;
         send_pixel(item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      // limit dropped below the darkest pixel of an open span
      set_levels(8'd255, 9'd128);
      send_pixel('{pixel: 8'd200, line_end: 1'b0}, 1'b0, NO_SPAN);
      send_pixel('{pixel: 8'd210, line_end: 1'b0}, 1'b0, NO_SPAN);
      set_levels(8'd64, 9'd128);
      send_pixel('{pixel: 8'd100, line_end: 1'b0}, 1'b0, NO_SPAN);
      send_pixel('{pixel: 8'd255, line_end: 1'b1}, 1'b0, NO_SPAN);

      for (i = 0; i < NUM_SWEEP; i++) begin
         set_levels(LIMIT_SWEEP[i], RATIO_SWEEP[i]);
         run_lines(SWEEP_ITEMS);
      end
      for (i = 0; i < 3; i++) begin
         set_levels(PIX_W'($urandom_range(0, 255)), RATIO_W'($urandom_range(0, 511)));
         run_lines(SWEEP_ITEMS);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_idle();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
